// ===== rtl/core/sdpg_pkg.sv =====
// sdpg_pkg: shared types and constants for the step/direction pulse generator
// depends on nothing; imported by step_dir_pulse_generator_core and tb
package sdpg_pkg;

  // default widths for the position counter and the step period
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int PERIOD_WIDTH_DEF   = 16;

  // command field width
  localparam int FUNC_WIDTH = 3;

  // reset level of the up-direction polarity register
  localparam logic UP_LEVEL_RST = 1'b1;

  // command codes carried in tuser
  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_UP     = 3'd1,
    FUNC_DOWN   = 3'd2,
    FUNC_STOP   = 3'd3,
    FUNC_ZERO   = 3'd4,
    FUNC_HOME   = 3'd5
  } func_t;

  // signed motion direction codes
  localparam logic signed [1:0] DIR_STOP = 2'sb00;
  localparam logic signed [1:0] DIR_DOWN = 2'sb01;
  localparam logic signed [1:0] DIR_UP   = 2'sb11;

endpackage

// ===== rtl/core/step_dir_pulse_generator_core.sv =====
// step_dir_pulse_generator_core: stepper step/direction generator, one command per transfer
// depends on sdpg_pkg (command codes, direction codes, default widths)
//
//   channel | ports                      | payload
//   --------+----------------------------+----------------------------------------------
//   input   | in_tvalid/in_tready        | tuser: func; tdata: period_us
//   result  | out_tvalid/out_tready      | tdata: step_out, dir_out, position, direction,
//           |                            |        homing (lowest bit first, zero padded)
//   config  | cfg_wr_en/cfg_wr_data      | up_level
//
// one command per clock while the result stream does not stall: an input register feeds
// the next-state logic (one position add/subtract and one period compare) into the result
// register, which loads the command's result when the output stage can take it
// a stalled result holds the output register; the input register still fills,
// so input stalls only when both stages are full and out_tready is low
// rst_n (synchronous) stops motion, zeroes position and sets up_level to 1
module step_dir_pulse_generator_core #(
  parameter int POSITION_WIDTH = sdpg_pkg::POSITION_WIDTH_DEF,
  parameter int PERIOD_WIDTH   = sdpg_pkg::PERIOD_WIDTH_DEF,
  localparam int OUT_BITS      = POSITION_WIDTH + 5,
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8,
  localparam int IN_TDATA_W    = ((PERIOD_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_TDATA_W-1:0]                in_tdata,   // period_us
  input  logic [sdpg_pkg::FUNC_WIDTH-1:0]      in_tuser,   // func
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // step_out, dir_out, position, direction, homing, then zero fill
  output logic [OUT_TDATA_W-1:0]               out_tdata,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_wr_data  // up_level
);

  import sdpg_pkg::*;

  // input register
  logic                          s1_valid_r;
  logic [FUNC_WIDTH-1:0]         s1_func_r;
  logic [PERIOD_WIDTH-1:0]       s1_period_r;

  // motion state
  logic [PERIOD_WIDTH-1:0]       phase_r, phase_nxt;
  logic [PERIOD_WIDTH-1:0]       period_r, period_nxt;
  logic [POSITION_WIDTH-1:0]     pos_r, pos_nxt;
  logic signed [1:0]             dir_r, dir_nxt;
  logic                          dir_level_r, dir_level_nxt;
  logic                          homing_r, homing_nxt;
  logic                          up_level_r;

  // result register
  logic                          out_valid_r;
  logic [OUT_TDATA_W-1:0]        out_tdata_r, out_tdata_nxt;

  // handshake
  logic                          out_load;
  logic                          s1_load;
  logic                          s1_fire;

  // working values
  logic [PERIOD_WIDTH-1:0]       period_fix;
  logic [PERIOD_WIDTH-1:0]       phase_inc;
  logic [POSITION_WIDTH-1:0]     pos_step;
  logic                          pos_not_pos;
  logic                          step_nxt;
  func_t                         func;

  // pipeline flow control
  assign out_load  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign s1_load   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // command decode helpers
  assign func        = func_t'(s1_func_r);
  assign period_fix  = (s1_period_r == '0) ? PERIOD_WIDTH'(1) : s1_period_r;
  assign phase_inc   = phase_r + PERIOD_WIDTH'(1);
  assign pos_step    = (dir_r == DIR_DOWN) ? (pos_r + POSITION_WIDTH'(1))
                                           : (pos_r - POSITION_WIDTH'(1));
  assign pos_not_pos = (pos_r == '0) || pos_r[POSITION_WIDTH-1];

  // next motion state for the command in the input register
  always_comb begin
    phase_nxt     = phase_r;
    period_nxt    = period_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    dir_level_nxt = dir_level_r;
    homing_nxt    = homing_r;
    case (func)
      FUNC_TICK: begin
        if (dir_r != DIR_STOP) begin
          if (phase_inc >= period_r) begin
            phase_nxt = '0;
            pos_nxt   = pos_step;
            // homing ends once the position is zero or below
            if (homing_r && ((pos_step == '0) || pos_step[POSITION_WIDTH-1])) begin
              dir_nxt    = DIR_STOP;
              homing_nxt = 1'b0;
            end
          end else begin
            phase_nxt = phase_inc;
          end
        end
      end
      FUNC_UP: begin
        period_nxt    = period_fix;
        phase_nxt     = '0;
        dir_nxt       = DIR_UP;
        dir_level_nxt = up_level_r;
        homing_nxt    = 1'b0;
      end
      FUNC_DOWN: begin
        period_nxt    = period_fix;
        phase_nxt     = '0;
        dir_nxt       = DIR_DOWN;
        dir_level_nxt = !up_level_r;
        homing_nxt    = 1'b0;
      end
      FUNC_STOP: begin
        phase_nxt  = '0;
        dir_nxt    = DIR_STOP;
        homing_nxt = 1'b0;
      end
      FUNC_ZERO: begin
        pos_nxt = '0;
        if (homing_r) begin
          phase_nxt  = '0;
          dir_nxt    = DIR_STOP;
          homing_nxt = 1'b0;
        end
      end
      FUNC_HOME: begin
        if (!pos_not_pos) begin
          period_nxt    = period_fix;
          phase_nxt     = '0;
          dir_nxt       = DIR_UP;
          dir_level_nxt = up_level_r;
          homing_nxt    = 1'b1;
        end else begin
          phase_nxt  = '0;
          dir_nxt    = DIR_STOP;
          homing_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result packing: step is high for the first half of the period
  assign step_nxt = (dir_nxt != DIR_STOP) &&
                    ({phase_nxt, 1'b0} < {1'b0, period_nxt});

  always_comb begin
    out_tdata_nxt = '0;
    out_tdata_nxt[OUT_BITS-1:0] = {homing_nxt, dir_nxt, pos_nxt, dir_level_nxt, step_nxt};
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      period_r    <= PERIOD_WIDTH'(1);
      pos_r       <= '0;
      dir_r       <= DIR_STOP;
      dir_level_r <= 1'b0;
      homing_r    <= 1'b0;
      up_level_r  <= UP_LEVEL_RST;
    end else begin
      if (cfg_wr_en) begin
        up_level_r <= cfg_wr_data;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        phase_r     <= phase_nxt;
        period_r    <= period_nxt;
        pos_r       <= pos_nxt;
        dir_r       <= dir_nxt;
        dir_level_r <= dir_level_nxt;
        homing_r    <= homing_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_func_r   <= in_tuser;
      s1_period_r <= in_tdata[PERIOD_WIDTH-1:0];
    end
    if (s1_fire) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  // homing only runs in the up direction
  assert property (@(posedge clk) disable iff (!rst_n) homing_r |-> (dir_r == DIR_UP))
    else $error("homing while not moving up");

  // stopped motion keeps the phase counter cleared
  assert property (@(posedge clk) disable iff (!rst_n) (dir_r == DIR_STOP) |-> (phase_r == '0))
    else $error("phase counter running while stopped");

  // phase always stays inside a nonzero period
  assert property (@(posedge clk) disable iff (!rst_n)
                   (period_r != '0) && (phase_r < period_r))
    else $error("phase counter outside period");

  // direction code is never the unused negative value
  assert property (@(posedge clk) disable iff (!rst_n) dir_r != 2'sb10)
    else $error("invalid direction code");

  // a result is loaded only when the input stage held a command
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_load && !s1_valid_r) |=> !out_valid_r)
    else $error("result valid without a command");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for step_dir_pulse_generator_core, with random stalls on both streams
// depends on sdpg_pkg (command codes, direction codes, widths) and the core rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdpg_pkg::*;

  localparam int POS_W       = POSITION_WIDTH_DEF;
  localparam int PER_W       = PERIOD_WIDTH_DEF;
  localparam int IN_TDATA_W  = ((PER_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((POS_W + 5 + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;

  // one reported motor status, as packed in out_tdata
  typedef struct packed {
    logic                   homing;
    logic signed [1:0]      direction;
    logic [POS_W-1:0]       position;
    logic                   dir_pin;
    logic                   step;
  } motor_status_t;

  // tracks the motor state and holds the statuses still to come back
  class motion_tracker;
    logic [PER_W-1:0]  phase_cnt;
    logic [PER_W-1:0]  period;
    logic [POS_W-1:0]  pos;
    logic signed [1:0] dir;
    logic              dir_pin;
    logic              homing;
    logic              up_lvl;
    motor_status_t     expected_status[$];
    int                errors;

    function new();
      phase_cnt = '0;
      period    = PER_W'(1);
      pos       = '0;
      dir       = DIR_STOP;
      dir_pin   = 1'b0;
      homing    = 1'b0;
      up_lvl    = UP_LEVEL_RST;
      errors    = 0;
    endfunction

    function void set_up_level(logic v);
      up_lvl = v;
    endfunction

    function void halt();
      dir       = DIR_STOP;
      homing    = 1'b0;
      phase_cnt = '0;
    endfunction

    function void start(logic signed [1:0] d, logic [PER_W-1:0] p);
      period    = (p == '0) ? PER_W'(1) : p;
      phase_cnt = '0;
      dir       = d;
      dir_pin   = (d == DIR_UP) ? up_lvl : ~up_lvl;
      homing    = 1'b0;
    endfunction

    function bit at_or_below_zero();
      return (pos == 0) || pos[POS_W-1];
    endfunction

    // apply one accepted command and queue the status it leaves behind
    function void note_command(logic [FUNC_WIDTH-1:0] func, logic [PER_W-1:0] p);
      motor_status_t s;
      case (func)
        FUNC_TICK: begin
          if (dir != DIR_STOP) begin
            phase_cnt = phase_cnt + 1'b1;
            if (phase_cnt >= period) begin
              phase_cnt = '0;
              pos = (dir == DIR_DOWN) ? pos + 1'b1 : pos - 1'b1;
              if (homing && at_or_below_zero()) halt();
            end
          end
        end
        FUNC_UP:   start(DIR_UP, p);
        FUNC_DOWN: start(DIR_DOWN, p);
        FUNC_STOP: halt();
        FUNC_ZERO: begin
          pos = '0;
          if (homing) halt();
        end
        FUNC_HOME: begin
          if (!at_or_below_zero()) begin
            start(DIR_UP, p);
            homing = 1'b1;
          end else begin
            halt();
          end
        end
        default: ;
      endcase
      s.step      = (dir != DIR_STOP) && ((int'(phase_cnt) * 2) < int'(period));
      s.dir_pin   = dir_pin;
      s.position  = pos;
      s.direction = dir;
      s.homing    = homing;
      expected_status.push_back(s);
    endfunction

    function void compare_field(string name, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // compare one result transfer with the oldest queued status
    function void check_result(logic [OUT_TDATA_W-1:0] d);
      motor_status_t exp_s;
      motor_status_t act_s;
      act_s = d[$bits(motor_status_t)-1:0];
      if (expected_status.size() == 0) begin
        $error("result transfer with no command outstanding: %0h", d);
        errors++;
      end else begin
        exp_s = expected_status.pop_front();
        compare_field("step_out", exp_s.step, act_s.step);
        compare_field("dir_out", exp_s.dir_pin, act_s.dir_pin);
        compare_field("position", exp_s.position, act_s.position);
        compare_field("direction", exp_s.direction, act_s.direction);
        compare_field("homing", exp_s.homing, act_s.homing);
        compare_field("padding", '0, d[OUT_TDATA_W-1:$bits(motor_status_t)]);
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;   // period_us
  logic [FUNC_WIDTH-1:0]   in_tuser;   // func
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;  // step_out, dir_out, position, direction, homing, zeros
  logic                    cfg_wr_en;
  logic                    cfg_wr_data;

  motion_tracker tracker = new();
  bit            hold_req;
  bit            hold_active;

  step_dir_pulse_generator_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both streams and the register port
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tracker.set_up_level(cfg_wr_data);
      if (in_tvalid && in_tready) tracker.note_command(in_tuser, in_tdata[PER_W-1:0]);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
    end
  end

  // mostly short gaps, a few long ones, none while the receiver holds off
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (hold_active || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // offer one command and wait for its transfer
  task automatic drive_command(logic [FUNC_WIDTH-1:0] func, logic [PER_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_TDATA_W'(p);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_up_level(logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // drop valid and let every status come back before returning
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random traffic: mostly ticks between moves with short periods
  task automatic run_random(int n, bit with_hold);
    int                    sent;
    int                    r;
    logic [FUNC_WIDTH-1:0] f;
    logic [PER_W-1:0]      p;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      p = ($urandom_range(0, 99) < 85) ? PER_W'($urandom_range(0, 6)) : PER_W'($urandom);
      if (r < 70) begin
        f = FUNC_TICK;
        p = PER_W'($urandom);
      end else if (r < 80) f = FUNC_DOWN;
      else if (r < 86) f = FUNC_UP;
      else if (r < 92) f = FUNC_HOME;
      else if (r < 95) f = FUNC_STOP;
      else if (r < 97) f = FUNC_ZERO;
      else f = FUNC_WIDTH'($urandom_range(6, 7));
      if (with_hold && sent == n / 4) hold_req = 1'b1;
      drive_command(f, p);
      if (f <= FUNC_HOME) sent++;
    end
  endtask

  // run limit
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // reset, directed commands, then random phases under both polarities
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    hold_req     = 1'b0;
    hold_active  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_up_level(1'b1);

    // tick while stopped, then period 0 behaves as 1 and steps every tick
    drive_command(FUNC_TICK, 16'hFFFF);
    drive_command(FUNC_DOWN, 16'd0);
    drive_command(FUNC_TICK, 16'd0);
    drive_command(FUNC_TICK, 16'hFFFF);
    drive_command(FUNC_DOWN, 16'd3);
    repeat (3) drive_command(FUNC_TICK, 16'd0);
    // return home runs until position reaches zero
    drive_command(FUNC_HOME, 16'd1);
    repeat (4) drive_command(FUNC_TICK, 16'd0);
    // longest period, then negative position
    drive_command(FUNC_UP, 16'hFFFF);
    drive_command(FUNC_TICK, 16'd0);
    drive_command(FUNC_UP, 16'd1);
    drive_command(FUNC_TICK, 16'd0);
    // home from negative and from zero stops at once
    drive_command(FUNC_HOME, 16'd5);
    drive_command(FUNC_ZERO, 16'd0);
    drive_command(FUNC_HOME, 16'd7);
    // zero while homing ends the homing move
    drive_command(FUNC_DOWN, 16'd1);
    repeat (2) drive_command(FUNC_TICK, 16'd0);
    drive_command(FUNC_HOME, 16'd2);
    drive_command(FUNC_ZERO, 16'd0);
    // a move while homing cancels it; then stop and the unused codes
    drive_command(FUNC_DOWN, 16'd2);
    repeat (2) drive_command(FUNC_TICK, 16'd0);
    drive_command(FUNC_HOME, 16'd2);
    drive_command(FUNC_DOWN, 16'd4);
    drive_command(FUNC_STOP, 16'd0);
    drive_command(3'd6, 16'h5555);
    drive_command(3'd7, 16'hAAAA);
    wait_drained();

    write_up_level(1'b0);
    run_random(400, 1'b1);
    wait_drained();

    write_up_level(1'b1);
    run_random(400, 1'b0);
    wait_drained();

    if (tracker.pending() != 0 || tracker.errors != 0) begin
      if (tracker.pending() != 0) $error("%0d statuses never returned", tracker.pending());
      $display("end of test: mismatches");
    end else begin
      $display("end of test: clean");
    end
    $finish;
  end

endmodule
